FILE: hdl/depth_frequency_dispatch_gate_unit_assert.svh
// Assertion macros for the depth frequency dispatch gate checker.
// Each macro expects a clock named clk and a reset named rst in the using scope.
`ifndef DEPTH_FREQUENCY_DISPATCH_GATE_UNIT_ASSERT_SVH
`define DEPTH_FREQUENCY_DISPATCH_GATE_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define DFDG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high
`define DFDG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset
`define DFDG_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

FILE: hdl/dfdg_pkg.sv
// Shared types, constants and codes of the depth frequency dispatch gate.
// No dependencies; the config interface, divider, controller, datapath, top level and checker import it.
`timescale 1ns / 1ps

package dfdg_pkg;

  // Delay slot table size and derived widths
  localparam int DELAY_SLOTS = 256;
  localparam int SLOT_W      = $clog2(DELAY_SLOTS);
  localparam int CNT_IN_W    = 8;
  localparam int CNT_OUT_W   = 9;
  localparam int DLY_W       = (SLOT_W + 1 > CNT_OUT_W) ? SLOT_W + 1 : CNT_OUT_W;

  // Iterative divider geometry
  localparam int DIV_N     = 17;
  localparam int DIV_D     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMING_MASK = 3'd0,
    CFG_FREQUENCY   = 3'd1,
    CFG_FREQ_OFFSET = 3'd2,
    CFG_MAX_DEPTH   = 3'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [10:0]        MASK_RESET = 11'd8;
  localparam logic signed [16:0] FREQ_RESET = 17'sd1;
  localparam logic [15:0]        OFS_RESET  = 16'd0;
  localparam logic signed [16:0] MAX_RESET  = -17'sd1;

  // Timing point bit indexes
  localparam logic [3:0] TP_AFTER_LP_NODE       = 4'd3;
  localparam logic [3:0] TP_AFTER_PSEUDO_NODE   = 4'd4;
  localparam logic [3:0] TP_AFTER_LP_PLUNGE     = 4'd5;
  localparam logic [3:0] TP_AFTER_PSEUDO_PLUNGE = 4'd6;
  localparam logic [3:0] TP_BEFORE_PRESOL       = 4'd8;
  localparam logic [3:0] TP_DURING_PRESOL       = 4'd9;

  // Outcome codes
  localparam logic [2:0] OUT_NOT_RUN = 3'd0;
  localparam logic [2:0] OUT_DELAYED = 3'd1;
  localparam logic [2:0] OUT_FOUND   = 3'd2;
  localparam logic [2:0] OUT_NONE    = 3'd3;
  localparam logic [2:0] OUT_INVALID = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic load;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_valid;
    logic div_done;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: hdl/dfdg_item_if.sv
// Input item channel of the dispatch gate: valid, ready and one node event.
// Depends on nothing.
`timescale 1ns / 1ps

interface dfdg_item_if;
  logic              valid;
  logic              ready;
  logic signed [16:0] node_depth;
  logic signed [16:0] fork_depth;
  logic [3:0]        timing_point;
  logic [7:0]        delayed_count_in;
  logic [2:0]        callback_outcome;
  logic [7:0]        new_solutions;
  logic [7:0]        new_best_solutions;

  modport source (
    output valid, node_depth, fork_depth, timing_point, delayed_count_in,
           callback_outcome, new_solutions, new_best_solutions,
    input  ready
  );

  modport sink (
    input  valid, node_depth, fork_depth, timing_point, delayed_count_in,
           callback_outcome, new_solutions, new_best_solutions,
    output ready
  );
endinterface

FILE: hdl/dfdg_result_if.sv
// Result channel of the dispatch gate: valid, ready and one decision.
// Depends on nothing.
`timescale 1ns / 1ps

interface dfdg_result_if;
  logic        valid;
  logic        ready;
  logic        executed;
  logic [2:0]  final_outcome;
  logic [8:0]  delayed_count_out;
  logic        resort_needed;
  logic [31:0] call_total;
  logic [31:0] solution_total;
  logic [31:0] best_solution_total;

  modport source (
    output valid, executed, final_outcome, delayed_count_out, resort_needed,
           call_total, solution_total, best_solution_total,
    input  ready
  );

  modport sink (
    input  valid, executed, final_outcome, delayed_count_out, resort_needed,
           call_total, solution_total, best_solution_total,
    output ready
  );
endinterface

FILE: hdl/dfdg_cfg_if.sv
// Configuration write channel of the dispatch gate: register index and data.
// Depends on dfdg_pkg for the index and data widths.
`timescale 1ns / 1ps

interface dfdg_cfg_if import dfdg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/dfdg_div.sv
// Restoring divider, one quotient bit per cycle, for the depth period tests.
// Depends on dfdg_pkg for the operand widths.
`timescale 1ns / 1ps

module dfdg_div import dfdg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic             done,
  output logic [DIV_N-1:0] quotient,
  output logic [DIV_D-1:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic [DIV_D:0]       partial;
  logic [DIV_D:0]       diff;
  logic                 fits;
  logic [DIV_D-1:0]     remainder_next;
  logic [DIV_N-1:0]     quotient_next;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    partial        = {remainder, quotient[DIV_N-1]};
    diff           = partial - {1'b0, divisor};
    fits           = partial >= {1'b0, divisor};
    remainder_next = fits ? diff[DIV_D-1:0] : partial[DIV_D-1:0];
    quotient_next  = {quotient[DIV_N-2:0], fits};
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CNT_W'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= quotient_next;
      remainder <= remainder_next;
    end
  end

endmodule

FILE: hdl/dfdg_ctrl.sv
// Controller of the dispatch gate: sequences load, division and commit.
// Depends on dfdg_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module dfdg_ctrl import dfdg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.item_valid) state_next = ST_START;
      end
      ST_START: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        cmd.load = status.item_valid;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
      end
      ST_DIVIDE: begin
        cmd = '0;
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/dfdg_dp.sv
// Datapath of the dispatch gate: config registers, item capture, the two
// period dividers, the run decision, delay slot, counters and result register.
// Depends on dfdg_pkg, dfdg_div and the result and config interfaces.
`timescale 1ns / 1ps

module dfdg_dp import dfdg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output ctrl_status_t       status,
  input  logic               item_valid,
  input  logic signed [16:0] node_depth_in,
  input  logic signed [16:0] fork_depth_in,
  input  logic [3:0]         timing_point_in,
  input  logic [7:0]         delayed_count_in,
  input  logic [2:0]         callback_outcome_in,
  input  logic [7:0]         new_solutions_in,
  input  logic [7:0]         new_best_solutions_in,
  dfdg_cfg_if.sink           cfg,
  dfdg_result_if.source      result
);

  // Configuration registers
  logic [10:0]        timing_mask;
  logic signed [16:0] frequency;
  logic [15:0]        frequency_offset;
  logic signed [16:0] max_depth;

  // Captured item
  logic signed [16:0] node_depth;
  logic signed [16:0] fork_depth;
  logic [3:0]         timing_point;
  logic [7:0]         delayed_count;
  logic [2:0]         callback_outcome;
  logic [7:0]         new_solutions;
  logic [7:0]         new_best_solutions;

  // Task state
  logic              slot_valid;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       run_counter;
  logic [31:0]       found_counter;
  logic [31:0]       best_counter;

  // Result register
  logic        out_valid;
  logic        res_executed;
  logic [2:0]  res_outcome;
  logic [8:0]  res_count;
  logic        res_resort;

  // Divider results
  logic             done_a;
  logic             done_b;
  logic [DIV_N-1:0] quo_a;
  logic [DIV_N-1:0] quo_b;
  logic [DIV_D-1:0] rem_a;
  logic [DIV_D-1:0] rem_b;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Accept every configuration write
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing_mask      <= MASK_RESET;
      frequency        <= FREQ_RESET;
      frequency_offset <= OFS_RESET;
      max_depth        <= MAX_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_TIMING_MASK: timing_mask      <= cfg.data[10:0];
        CFG_FREQUENCY:   frequency        <= $signed(cfg.data[16:0]);
        CFG_FREQ_OFFSET: frequency_offset <= cfg.data[15:0];
        CFG_MAX_DEPTH:   max_depth        <= $signed(cfg.data[16:0]);
        default: begin
        end
      endcase
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_depth         <= node_depth_in;
      fork_depth         <= fork_depth_in;
      timing_point       <= timing_point_in;
      delayed_count      <= delayed_count_in;
      callback_outcome   <= callback_outcome_in;
      new_solutions      <= new_solutions_in;
      new_best_solutions <= new_best_solutions_in;
    end
  end

  // Operand preparation
  logic               f_nonneg;
  logic               f_zero;
  logic               f_pos;
  logic signed [17:0] depth_x;
  logic signed [17:0] ofs_x;
  logic signed [17:0] rel_c;
  logic signed [18:0] num_a;
  logic signed [18:0] num_b;
  logic               d_ge;
  logic               d_eq;
  logic [15:0]        mask_wide;
  logic               in_mask;
  logic               case_presol;
  logic               case_skip;
  logic [DIV_N-1:0]   dividend_a;

  always_comb begin
    f_nonneg    = !frequency[16];
    f_zero      = frequency == 17'sd0;
    f_pos       = f_nonneg && !f_zero;
    depth_x     = $signed({node_depth[16], node_depth});
    ofs_x       = $signed({2'b00, frequency_offset});
    rel_c       = depth_x - ofs_x;
    num_a       = $signed({{2{node_depth[16]}}, node_depth})
                + $signed({{2{frequency[16]}}, frequency})
                - $signed({3'b000, frequency_offset});
    num_b       = $signed({{2{fork_depth[16]}}, fork_depth})
                + $signed({{2{frequency[16]}}, frequency})
                - $signed({3'b000, frequency_offset});
    d_ge        = depth_x >= ofs_x;
    d_eq        = depth_x == ofs_x;
    mask_wide   = {5'b00000, timing_mask};
    in_mask     = mask_wide[timing_point];
    case_presol = in_mask && (timing_point == TP_BEFORE_PRESOL ||
                              timing_point == TP_DURING_PRESOL);
    case_skip   = !case_presol && !timing_mask[TP_AFTER_PSEUDO_NODE] &&
                  (timing_point == TP_AFTER_LP_NODE || timing_point == TP_AFTER_LP_PLUNGE);
    dividend_a  = case_skip ? num_a[DIV_N-1:0] : rel_c[DIV_N-1:0];
  end

  // Period dividers: node term and fork term run side by side
  dfdg_div u_div_a (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend_a),
    .divisor   (frequency[DIV_D-1:0]),
    .done      (done_a),
    .quotient  (quo_a),
    .remainder (rem_a)
  );

  dfdg_div u_div_b (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (num_b[DIV_N-1:0]),
    .divisor   (frequency[DIV_D-1:0]),
    .done      (done_b),
    .quotient  (quo_b),
    .remainder (rem_b)
  );

  // Run decision
  logic base_run;
  logic run_limited;
  logic run_forced;
  logic plunge_only;
  logic delayed;
  logic run_final;
  logic invalid;

  always_comb begin
    if (case_presol) begin
      base_run = f_nonneg;
    end else if (case_skip) begin
      // a negative fork term truncates to a quotient of zero or below
      base_run = f_pos && d_ge && (num_b[18] || (quo_a != quo_b));
    end else begin
      base_run = f_pos && d_ge && (rem_a == '0);
    end
    run_limited = (base_run || (d_eq && f_zero)) &&
                  (max_depth == -17'sd1 || node_depth <= max_depth);
    run_forced  = run_limited || slot_valid;
    plunge_only = (timing_point == TP_AFTER_LP_NODE && !timing_mask[TP_AFTER_LP_NODE] &&
                   timing_mask[TP_AFTER_LP_PLUNGE]) ||
                  (timing_point == TP_AFTER_PSEUDO_NODE &&
                   !timing_mask[TP_AFTER_PSEUDO_NODE] &&
                   timing_mask[TP_AFTER_PSEUDO_PLUNGE]);
    delayed     = run_forced && plunge_only;
    run_final   = run_forced && !plunge_only && in_mask;
    invalid     = callback_outcome >= OUT_INVALID;
  end

  // Delay slot bookkeeping values
  logic [DLY_W-1:0] cnt_x;
  logic [DLY_W-1:0] slot_cap;
  logic [DLY_W-1:0] cnt_inc;
  logic [DLY_W-1:0] cnt_cap;

  always_comb begin
    cnt_x    = DLY_W'(delayed_count);
    slot_cap = (cnt_x < DLY_W'(DELAY_SLOTS - 1)) ? cnt_x : DLY_W'(DELAY_SLOTS - 1);
    cnt_inc  = cnt_x + DLY_W'(1);
    cnt_cap  = (cnt_inc < DLY_W'(DELAY_SLOTS)) ? cnt_inc : DLY_W'(DELAY_SLOTS);
  end

  // Next task state and result
  logic              slot_valid_next;
  logic [SLOT_W-1:0] slot_next;
  logic [31:0]       run_counter_next;
  logic [31:0]       found_counter_next;
  logic [31:0]       best_counter_next;
  logic [2:0]        outcome_next;
  logic [8:0]        count_next;
  logic              resort_next;

  always_comb begin
    slot_valid_next    = slot_valid;
    slot_next          = slot;
    run_counter_next   = run_counter;
    found_counter_next = found_counter;
    best_counter_next  = best_counter;
    outcome_next       = OUT_NOT_RUN;
    count_next         = {1'b0, delayed_count};
    resort_next        = 1'b0;
    if (run_final && invalid) begin
      outcome_next = OUT_INVALID;
    end else begin
      if (delayed) outcome_next = OUT_DELAYED;
      if (run_final) begin
        outcome_next = callback_outcome;
        if (callback_outcome == OUT_FOUND || callback_outcome == OUT_NONE) begin
          run_counter_next = sat_add(run_counter, 32'd1);
        end
        found_counter_next = sat_add(found_counter, {24'd0, new_solutions});
        best_counter_next  = sat_add(best_counter, {24'd0, new_best_solutions});
        if (callback_outcome != OUT_DELAYED && slot_valid) begin
          slot_valid_next = 1'b0;
          resort_next     = 1'b1;
        end
      end
      // take or renew the delay slot
      if (outcome_next == OUT_DELAYED || slot_valid_next) begin
        if (!slot_valid_next || slot_next != slot_cap[SLOT_W-1:0]) resort_next = 1'b1;
        slot_valid_next = 1'b1;
        slot_next       = slot_cap[SLOT_W-1:0];
        count_next      = cnt_cap[CNT_OUT_W-1:0];
      end
    end
  end

  // Commit task state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= 1'b0;
      run_counter   <= '0;
      found_counter <= '0;
      best_counter  <= '0;
    end else if (cmd.commit) begin
      slot_valid    <= slot_valid_next;
      run_counter   <= run_counter_next;
      found_counter <= found_counter_next;
      best_counter  <= best_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) slot <= slot_next;
  end

  // Result register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_executed <= run_final;
      res_outcome  <= outcome_next;
      res_count    <= count_next;
      res_resort   <= resort_next;
    end
  end

  assign result.valid               = out_valid;
  assign result.executed            = res_executed;
  assign result.final_outcome       = res_outcome;
  assign result.delayed_count_out   = res_count;
  assign result.resort_needed       = res_resort;
  assign result.call_total          = run_counter;
  assign result.solution_total      = found_counter;
  assign result.best_solution_total = best_counter;

  // Status to the controller
  assign status.item_valid = item_valid;
  assign status.div_done   = done_a && done_b;
  assign status.out_free   = !out_valid || result.ready;

endmodule

FILE: hdl/depth_frequency_dispatch_gate_unit.sv
// Depth frequency dispatch gate: decides per search-node event whether the task runs.
// Depends on dfdg_pkg, the three channel interfaces, dfdg_ctrl and dfdg_dp.
`timescale 1ns / 1ps

// One node event is processed at a time. After the input transfer the controller
// passes through the divider start state, waits while the two 17-bit restoring
// dividers work out the node term and fork term side by side, and then commits the
// result once the output register is free. Input ready returns in the cycle after
// the commit, so no new event is taken before the last one is committed. The
// result then waits in the output register, and a stalled result sink costs nothing
// until a second result is ready to commit. Input ready stays low while reset is high.
// Configuration writes are taken in every cycle; there is no clearing pass after reset.

module depth_frequency_dispatch_gate_unit import dfdg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  dfdg_item_if.sink     item,
  dfdg_result_if.source result,
  dfdg_cfg_if.sink      cfg
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Input ready comes from the controller; hold it low during reset
  assign item.ready = cmd.take && !rst;

  dfdg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  dfdg_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .item_valid            (item.valid),
    .node_depth_in         (item.node_depth),
    .fork_depth_in         (item.fork_depth),
    .timing_point_in       (item.timing_point),
    .delayed_count_in      (item.delayed_count_in),
    .callback_outcome_in   (item.callback_outcome),
    .new_solutions_in      (item.new_solutions),
    .new_best_solutions_in (item.new_best_solutions),
    .cfg                   (cfg),
    .result                (result)
  );

endmodule

FILE: hdl/dfdg_checker.sv
// Port-level checker for the dispatch gate, bound to the top level.
// Depends on dfdg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "depth_frequency_dispatch_gate_unit_assert.svh"

module dfdg_checker import dfdg_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic       executed,
  input logic [2:0] final_outcome,
  input logic       resort_needed
);

  // Hold a pending result until its transfer
  `DFDG_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped before transfer")

  // Invalid outcome only on a run, and it never moves the delay slot
  `DFDG_ASSERT_IMP(a_invalid_run, result_valid && final_outcome == OUT_INVALID, executed && !resort_needed, "invalid outcome without run or with resort")

  // A task that did not run reports not run or delayed
  `DFDG_ASSERT_IMP(a_idle_outcome, result_valid && !executed, final_outcome == OUT_NOT_RUN || final_outcome == OUT_DELAYED, "bad outcome for a task that did not run")

  // One event at a time: no new input right after a transfer
  `DFDG_ASSERT_NXT(a_one_in_flight, item_valid && item_ready, !item_ready, "input taken while an event is in work")

  // No result straight out of reset
  `DFDG_ASSERT_RST(a_reset_empty, !result_valid, "result valid after reset")

endmodule

bind depth_frequency_dispatch_gate_unit dfdg_checker u_dfdg_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .executed      (result.executed),
  .final_outcome (result.final_outcome),
  .resort_needed (result.resort_needed)
);
